### hdl/cdd_pkg.sv
// Shared types, constants and sizing functions of the corner dedup table.
package cdd_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam logic [11:0] MIN_DIST_RESET = 12'd128;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  typedef struct packed {
    logic        [15:0] x;
    logic        [15:0] y;
    logic        [7:0]  radius;
    logic signed [15:0] dir1_x;
    logic signed [15:0] dir1_y;
    logic signed [15:0] dir2_x;
    logic signed [15:0] dir2_y;
    logic        [15:0] quality;
  } entry_t;

  typedef struct packed {
    logic        valid;
    logic        hit;
    logic [15:0] quality;
    logic        pending;
  } dist_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  function automatic int cnt_w(input int depth);
    return $clog2(depth + 1);
  endfunction

endpackage

### hdl/cdd_store.sv
// Entry memory: one write port, one registered read port.
module cdd_store #(
  parameter int TABLE_DEPTH = cdd_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [cdd_pkg::addr_w(TABLE_DEPTH)-1:0] wr_addr,
  input  cdd_pkg::entry_t                        wr_data,
  input  logic                                   rd_en,
  input  logic [cdd_pkg::addr_w(TABLE_DEPTH)-1:0] rd_addr,
  output cdd_pkg::entry_t                        rd_data
);

  cdd_pkg::entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/cdd_dist.sv
// Pipelined squared-distance compare unit, one stored entry per cycle.
module cdd_dist (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic               issue,
  input  logic [11:0]        dist_limit,
  input  logic [15:0]        new_x,
  input  logic [15:0]        new_y,
  input  cdd_pkg::entry_t    ent,
  output cdd_pkg::dist_res_t res
);

  logic [23:0] thr;
  logic        v0, v1, v2, v3;
  logic [15:0] dx, dy;
  logic [15:0] q1, q2, q3;
  logic [31:0] sx, sy;
  logic        hit;

  always_ff @(posedge clk) begin
    thr <= 24'(dist_limit) * 24'(dist_limit);
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= issue;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    dx  <= (ent.x > new_x) ? ent.x - new_x : new_x - ent.x;
    dy  <= (ent.y > new_y) ? ent.y - new_y : new_y - ent.y;
    q1  <= ent.quality;
    sx  <= 32'(dx) * 32'(dx);
    sy  <= 32'(dy) * 32'(dy);
    q2  <= q1;
    hit <= (33'(sx) + 33'(sy)) < 33'(thr);
    q3  <= q2;
  end

  always_comb begin
    res.valid   = v3;
    res.hit     = hit;
    res.quality = q3;
    res.pending = v0 | v1 | v2 | v3;
  end

endmodule

### hdl/cdd_ctrl.sv
// Sequencer: scan, replace or append on insert, read-out and clear on flush.
module cdd_ctrl #(
  parameter int TABLE_DEPTH = cdd_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   kind,
  input  cdd_pkg::entry_t                        in_ent,
  output logic [15:0]                            new_x,
  output logic [15:0]                            new_y,
  output logic                                   dist_issue,
  output logic                                   dist_clear,
  input  cdd_pkg::dist_res_t                     res,
  output logic                                   rd_en,
  output logic [cdd_pkg::addr_w(TABLE_DEPTH)-1:0] rd_addr,
  input  cdd_pkg::entry_t                        rd_data,
  output logic                                   wr_en,
  output logic [cdd_pkg::addr_w(TABLE_DEPTH)-1:0] wr_addr,
  output cdd_pkg::entry_t                        wr_data,
  output logic                                   strobe,
  output cdd_pkg::entry_t                        out_ent,
  output logic                                   last,
  output logic                                   empty_res,
  output logic                                   overflow
);

  localparam int AW = cdd_pkg::addr_w(TABLE_DEPTH);
  localparam int CW = cdd_pkg::cnt_w(TABLE_DEPTH);
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

  cdd_pkg::state_t state, state_next;
  logic [CW-1:0]   count;
  logic            flag;
  logic [CW-1:0]   idx;
  logic [CW-1:0]   ret;
  cdd_pkg::entry_t item;
  logic            fl_v;
  logic            fl_last;
  logic            accept;
  logic            hit_now;
  logic            miss_done;
  logic            flush_done;

  assign busy   = (state != cdd_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign new_x  = item.x;
  assign new_y  = item.y;

  always_comb begin
    hit_now    = (state == cdd_pkg::ST_SCAN) && res.valid && res.hit;
    miss_done  = (state == cdd_pkg::ST_SCAN) && (idx == count) && !res.pending;
    flush_done = (state == cdd_pkg::ST_FLUSH) && (idx == count) && !fl_v;
  end

  always_comb begin
    state_next = state;
    case (state)
      cdd_pkg::ST_IDLE: begin
        if (accept) begin
          if (kind == cdd_pkg::KIND_INSERT) begin
            state_next = cdd_pkg::ST_SCAN;
          end else if (count != '0) begin
            state_next = cdd_pkg::ST_FLUSH;
          end
        end
      end
      cdd_pkg::ST_SCAN: begin
        if (hit_now || miss_done) begin
          state_next = cdd_pkg::ST_IDLE;
        end
      end
      cdd_pkg::ST_FLUSH: begin
        if (flush_done) begin
          state_next = cdd_pkg::ST_IDLE;
        end
      end
      default: state_next = cdd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en      = busy && (idx != count);
    rd_addr    = idx[AW-1:0];
    dist_issue = (state == cdd_pkg::ST_SCAN) && rd_en;
    dist_clear = (state != cdd_pkg::ST_SCAN);
    wr_en      = (hit_now && (item.quality > res.quality)) ||
                 (miss_done && (count != FULL));
    wr_addr    = hit_now ? ret[AW-1:0] : count[AW-1:0];
    wr_data    = item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= cdd_pkg::ST_IDLE;
      count  <= '0;
      flag   <= 1'b0;
      strobe <= 1'b0;
      fl_v   <= 1'b0;
      idx    <= '0;
      ret    <= '0;
    end else begin
      state   <= state_next;
      strobe  <= (accept && (kind == cdd_pkg::KIND_FLUSH) && (count == '0)) || fl_v;
      fl_v    <= (state == cdd_pkg::ST_FLUSH) && rd_en;
      fl_last <= (CW'(idx + 1'b1) == count);
      if (accept) begin
        idx  <= '0;
        ret  <= '0;
        item <= in_ent;
        if ((kind == cdd_pkg::KIND_FLUSH) && (count == '0)) begin
          out_ent   <= '0;
          last      <= 1'b1;
          empty_res <= 1'b1;
          overflow  <= flag;
          flag      <= 1'b0;
        end
      end
      if (rd_en) begin
        idx <= idx + 1'b1;
      end
      if ((state == cdd_pkg::ST_SCAN) && res.valid) begin
        ret <= ret + 1'b1;
      end
      if (miss_done) begin
        if (count == FULL) begin
          flag <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
      end
      if (fl_v) begin
        out_ent   <= rd_data;
        last      <= fl_last;
        empty_res <= 1'b0;
        overflow  <= flag;
      end
      if (flush_done) begin
        count <= '0;
        flag  <= 1'b0;
      end
    end
  end

endmodule

### hdl/corner_distance_dedup_table.sv
// Top level of the corner distance dedup table.
//
//  channel   signals                              direction
//  -------   -----------------------------------  ---------
//  item      start, busy, kind, pos_x .. quality  in
//  result    strobe, out_x .. overflow            out
//  config    cfg_valid, cfg_ready, cfg_data       in
//
// Insert: scans the stored entries and ends early when a near entry hits the limit;
// one entry per cycle through the memory read and 3 compare stages.
// Flush: reads out every entry; an empty flush answers next cycle without going busy.
// Reset clears the entry count and overflow flag; memory is not cleared.
// Results appear on strobe for one cycle each and cannot be stalled.
module corner_distance_dedup_table #(
  parameter int TABLE_DEPTH = cdd_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               kind,
  input  logic        [15:0] pos_x,
  input  logic        [15:0] pos_y,
  input  logic        [7:0]  radius,
  input  logic signed [15:0] dir1_x,
  input  logic signed [15:0] dir1_y,
  input  logic signed [15:0] dir2_x,
  input  logic signed [15:0] dir2_y,
  input  logic        [15:0] quality,
  output logic               strobe,
  output logic        [15:0] out_x,
  output logic        [15:0] out_y,
  output logic        [7:0]  out_radius,
  output logic signed [15:0] out_dir1_x,
  output logic signed [15:0] out_dir1_y,
  output logic signed [15:0] out_dir2_x,
  output logic signed [15:0] out_dir2_y,
  output logic        [15:0] out_quality,
  output logic               last,
  output logic               empty_res,
  output logic               overflow,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [11:0] cfg_data
);

  localparam int AW = cdd_pkg::addr_w(TABLE_DEPTH);

  logic [11:0]        dist_limit;
  cdd_pkg::entry_t    in_ent;
  cdd_pkg::entry_t    out_ent;
  cdd_pkg::entry_t    rd_data;
  cdd_pkg::entry_t    wr_data;
  cdd_pkg::dist_res_t res;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               dist_issue, dist_clear;
  logic [15:0]        new_x, new_y;

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_limit <= cdd_pkg::MIN_DIST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dist_limit <= cfg_data;
    end
  end

  always_comb begin
    in_ent.x       = pos_x;
    in_ent.y       = pos_y;
    in_ent.radius  = radius;
    in_ent.dir1_x  = dir1_x;
    in_ent.dir1_y  = dir1_y;
    in_ent.dir2_x  = dir2_x;
    in_ent.dir2_y  = dir2_y;
    in_ent.quality = quality;
  end

  assign out_x       = out_ent.x;
  assign out_y       = out_ent.y;
  assign out_radius  = out_ent.radius;
  assign out_dir1_x  = out_ent.dir1_x;
  assign out_dir1_y  = out_ent.dir1_y;
  assign out_dir2_x  = out_ent.dir2_x;
  assign out_dir2_y  = out_ent.dir2_y;
  assign out_quality = out_ent.quality;

  cdd_store #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cdd_dist u_dist (
    .clk        (clk),
    .rst        (rst),
    .clear      (dist_clear),
    .issue      (dist_issue),
    .dist_limit (dist_limit),
    .new_x      (new_x),
    .new_y      (new_y),
    .ent        (rd_data),
    .res        (res)
  );

  cdd_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .in_ent     (in_ent),
    .new_x      (new_x),
    .new_y      (new_y),
    .dist_issue (dist_issue),
    .dist_clear (dist_clear),
    .res        (res),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .strobe     (strobe),
    .out_ent    (out_ent),
    .last       (last),
    .empty_res  (empty_res),
    .overflow   (overflow)
  );

endmodule

### hdl/cdd_checker.sv
// Port-level checks of the corner dedup table, bound to the top level.
module cdd_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic kind,
  input logic strobe,
  input logic last,
  input logic empty_res,
  input logic overflow
);

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && empty_res |-> last)
    else $error("empty result without last mark");

  a_insert_goes_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (kind == cdd_pkg::KIND_INSERT) |=> busy)
    else $error("accepted insert did not start a scan");

  a_flush_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe && (overflow == $past(overflow)))
    else $error("flush burst broken or overflow changed inside it");

  a_entry_result_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !empty_res |-> busy)
    else $error("table entry result outside a flush");

endmodule

bind corner_distance_dedup_table cdd_checker u_cdd_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .kind      (kind),
  .strobe    (strobe),
  .last      (last),
  .empty_res (empty_res),
  .overflow  (overflow)
);
